>>> hdl/ps2a_pkg.sv
`default_nettype none
package ps2a_pkg;

    // fifo geometry
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam int LVL_W      = PTR_W + 1;
    localparam int EXT_W      = (LVL_W > 9) ? LVL_W : 9;

    // scancode map
    localparam int MAP_LEN = 58;
    localparam int MAP_W   = 6;

    // scancodes and masks
    localparam logic [7:0] SC_RELEASE   = 8'h80;
    localparam logic [7:0] SC_CODE_MASK = 8'h7F;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_CTRL      = 8'h1D;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] CTRL_MASK    = 8'h1F;
    localparam logic [7:0] CH_ETX       = 8'h03;
    localparam logic [7:0] CH_SUB       = 8'h1A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // command codes
    typedef enum logic [1:0] {
        CMD_SCAN   = 2'd0,
        CMD_INJECT = 2'd1,
        CMD_POP    = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    // signal codes
    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_INT  = 2'd1,
        SIG_STOP = 2'd2
    } t_sig;

    // work handed from front to back
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        t_sig       sig;
    } t_work;

    // us-qwerty set-1 tables
    localparam logic [7:0] PLAIN_MAP [MAP_LEN] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] SHIFT_MAP [MAP_LEN] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

endpackage
`default_nettype wire

>>> hdl/ps2a_if.sv
`default_nettype none
// input item channel
interface ps2a_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       foreground_active;

    modport source (output valid, cmd, data_byte, foreground_active, input ready);
    modport sink (input valid, cmd, data_byte, foreground_active, output ready);
endinterface

// result channel
interface ps2a_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       char_valid;
    logic [1:0] signal_code;
    logic       pushed;
    logic       dropped;
    logic [7:0] fifo_count;

    modport source (output valid, char_out, char_valid, signal_code, pushed, dropped,
                    fifo_count, input ready);
    modport sink (input valid, char_out, char_valid, signal_code, pushed, dropped,
                  fifo_count, output ready);
endinterface
`default_nettype wire

>>> hdl/ps2a_front.sv
`default_nettype none
module ps2a_front
    import ps2a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_foreground_active,
    input  wire logic       i_q_ready,
    output logic            o_ready,
    output logic            o_q_valid,
    output t_work           o_q_work
);

    logic r_shift, r_ctrl, r_caps;
    logic n_shift, n_ctrl, n_caps;
    logic accept;
    logic [7:0] code, map_ch, ch;
    logic is_letter;
    t_work work;

    assign accept    = i_valid && i_q_ready;
    assign o_ready   = i_q_ready;
    assign o_q_valid = accept;
    assign o_q_work  = work;
    assign code      = i_data_byte & SC_CODE_MASK;

    // table lookup with shift, caps lock and ctrl
    always_comb begin
        map_ch = 8'h00;
        if (i_data_byte < 8'(MAP_LEN)) begin
            if (r_shift) begin
                map_ch = SHIFT_MAP[i_data_byte[MAP_W-1:0]];
            end else begin
                map_ch = PLAIN_MAP[i_data_byte[MAP_W-1:0]];
                if (r_caps && map_ch >= 8'h61 && map_ch <= 8'h7A) begin
                    map_ch = map_ch - CASE_OFFSET;
                end
            end
        end
        is_letter = (map_ch >= 8'h61 && map_ch <= 8'h7A)
                 || (map_ch >= 8'h41 && map_ch <= 8'h5A);
        ch = (r_ctrl && is_letter) ? (map_ch & CTRL_MASK) : map_ch;
    end

    // classify the item and update modifiers
    always_comb begin
        n_shift = r_shift;
        n_ctrl  = r_ctrl;
        n_caps  = r_caps;
        work.op  = OP_NONE;
        work.ch  = 8'h00;
        work.sig = SIG_NONE;
        unique case (t_cmd'(i_cmd))
            CMD_SCAN: begin
                if ((i_data_byte & SC_RELEASE) != 8'h00) begin
                    if (code == SC_LSHIFT || code == SC_RSHIFT) n_shift = 1'b0;
                    if (code == SC_CTRL) n_ctrl = 1'b0;
                end else if (i_data_byte == SC_LSHIFT || i_data_byte == SC_RSHIFT) begin
                    n_shift = 1'b1;
                end else if (i_data_byte == SC_CTRL) begin
                    n_ctrl = 1'b1;
                end else if (i_data_byte == SC_CAPS) begin
                    n_caps = !r_caps;
                end else if (i_foreground_active && ch == CH_ETX) begin
                    work.sig = SIG_INT;
                end else if (i_foreground_active && ch == CH_SUB) begin
                    work.sig = SIG_STOP;
                end else if (ch != 8'h00) begin
                    work.op = OP_PUSH;
                    work.ch = ch;
                end
            end
            CMD_INJECT: begin
                if (i_data_byte != 8'h00) begin
                    work.op = OP_PUSH;
                    work.ch = i_data_byte;
                end
            end
            CMD_POP: work.op = OP_POP;
            default: work.op = OP_NONE;
        endcase
    end

    // modifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
            r_caps  <= 1'b0;
        end else if (accept) begin
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
            r_caps  <= n_caps;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ps2a_queue.sv
`default_nettype none
module ps2a_queue
    import ps2a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_work i_work,
    output logic       o_ready,
    output logic       o_valid,
    output t_work      o_work,
    input  wire logic  i_ready
);

    t_work      r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_slot[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // two-entry skid queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wr] <= i_work;
    end

endmodule
`default_nettype wire

>>> hdl/ps2a_back.sv
`default_nettype none
module ps2a_back
    import ps2a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_work i_work,
    output logic       o_ready,
    ps2a_result_if.source o_result
);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_rp, r_wp, n_rp, n_wp, rp_inc, wp_inc;
    logic [7:0]       r_rd_data;
    logic             r_out_valid, r_char_valid, r_pushed, r_dropped;
    logic             n_char_valid, n_pushed, n_dropped;
    t_sig             r_sig;
    logic [7:0]       r_count, n_count;
    logic [LVL_W-1:0] lvl;
    logic [EXT_W-1:0] lvl_ext;
    logic             take, full, empty, we, re;

    assign o_ready = !r_out_valid || o_result.ready;
    assign take    = i_valid && o_ready;

    assign rp_inc = (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign wp_inc = (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign full   = (wp_inc == r_rp);
    assign empty  = (r_rp == r_wp);

    // pointer update and flags
    always_comb begin
        we = 1'b0;
        re = 1'b0;
        n_rp = r_rp;
        n_wp = r_wp;
        n_char_valid = 1'b0;
        n_pushed = 1'b0;
        n_dropped = 1'b0;
        unique case (i_work.op)
            OP_PUSH: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_pushed = 1'b1;
                    we = take;
                    n_wp = wp_inc;
                end
            end
            OP_POP: begin
                if (!empty) begin
                    n_char_valid = 1'b1;
                    re = take;
                    n_rp = rp_inc;
                end
            end
            default: ;
        endcase
    end

    // level after this transaction, saturated to eight bits
    always_comb begin
        if (n_wp >= n_rp) begin
            lvl = LVL_W'(n_wp) - LVL_W'(n_rp);
        end else begin
            lvl = LVL_W'(n_wp) + LVL_W'(FIFO_DEPTH) - LVL_W'(n_rp);
        end
        lvl_ext = EXT_W'(lvl);
        n_count = (lvl_ext > EXT_W'(255)) ? 8'hFF : lvl_ext[7:0];
    end

    // character store
    always_ff @(posedge i_clk) begin
        if (we) mem[r_wp] <= i_work.ch;
        if (re) r_rd_data <= mem[r_rp];
    end

    // pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
            r_wp <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_rp <= n_rp;
                r_wp <= n_wp;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char_valid <= n_char_valid;
            r_pushed     <= n_pushed;
            r_dropped    <= n_dropped;
            r_sig        <= i_work.sig;
            r_count      <= n_count;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.char_out    = r_char_valid ? r_rd_data : 8'h00;
    assign o_result.char_valid  = r_char_valid;
    assign o_result.signal_code = r_sig;
    assign o_result.pushed      = r_pushed;
    assign o_result.dropped     = r_dropped;
    assign o_result.fifo_count  = r_count;

endmodule
`default_nettype wire

>>> hdl/ps2_scancode_to_ascii_fifo.sv
`default_nettype none
// channel    | dir | handshake   | payload
// i_item     | in  | valid/ready | cmd, data_byte, foreground_active
// o_result   | out | valid/ready | char_out, char_valid, signal_code, pushed,
//            |     |             | dropped, fifo_count
//
// one transaction per cycle sustained while the output is not stalled; the front
// decode writes each item into the queue, then the back stage moves it into the
// output register, which also registers the store read.
// reset clears modifiers, pointers, queue and output valid; the store is not
// cleared, only written entries are ever read.
// a stalled output holds its result while the two-entry queue takes items until full.
module ps2_scancode_to_ascii_fifo
    import ps2a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ps2a_item_if.sink       i_item,
    ps2a_result_if.source   o_result
);

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    t_work fq_work, qb_work;

    // decode and modifier tracking
    ps2a_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_item.valid),
        .i_cmd               (i_item.cmd),
        .i_data_byte         (i_item.data_byte),
        .i_foreground_active (i_item.foreground_active),
        .i_q_ready           (fq_ready),
        .o_ready             (i_item.ready),
        .o_q_valid           (fq_valid),
        .o_q_work            (fq_work)
    );

    // decoupling queue
    ps2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .i_work  (fq_work),
        .o_ready (fq_ready),
        .o_valid (qb_valid),
        .o_work  (qb_work),
        .i_ready (qb_ready)
    );

    // character fifo and result register
    ps2a_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qb_valid),
        .i_work   (qb_work),
        .o_ready  (qb_ready),
        .o_result (o_result)
    );

    // a transaction never both stores and loses a character
    a_push_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.pushed && o_result.dropped))
        else $error("pushed and dropped together");

    // a popped character excludes push, drop and signal
    a_pop_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.char_valid) |->
            (!o_result.pushed && !o_result.dropped && o_result.signal_code == SIG_NONE))
        else $error("pop result mixed with other outcome");

    // character output is zero unless a stored character was returned
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.char_valid) |-> (o_result.char_out == 8'h00))
        else $error("char_out nonzero without char_valid");

    // a signal transaction never touches the fifo
    a_sig_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.signal_code != SIG_NONE) |->
            (!o_result.pushed && !o_result.dropped))
        else $error("signal with fifo activity");

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;
    import ps2a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_GOAL   = 1800;
    localparam int REPORT_MAX  = 10;

    // scancodes used by directed and biased stimulus
    localparam logic [7:0] KEY_1 = 8'h02;
    localparam logic [7:0] KEY_Q = 8'h10;
    localparam logic [7:0] KEY_A = 8'h1E;
    localparam logic [7:0] KEY_Z = 8'h2C;
    localparam logic [7:0] KEY_C = 8'h2E;

    // one result as seen on the output channel
    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic [1:0] signal_code;
        logic       pushed;
        logic       dropped;
        logic [7:0] fifo_count;
    } t_key_result;

    // keyboard state tracker and queue of predicted results
    class key_decode_board;
        logic [7:0] plain_keys [MAP_LEN] = '{
            8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
            8'h08, 8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]",
            8'h0A, 8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60,
            8'h00, "\\", "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00,
            "*", 8'h00, " "
        };
        logic [7:0] shift_keys [MAP_LEN] = '{
            8'h00, 8'h00, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+",
            8'h08, 8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}",
            8'h0A, 8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", "\"", "~",
            8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00,
            "*", 8'h00, " "
        };
        logic [7:0]  char_ring [FIFO_DEPTH];
        int          rd_idx;
        int          wr_idx;
        bit          shift_on;
        bit          ctrl_on;
        bit          caps_latched;
        t_key_result expected_q [$];
        int          checked;
        int          mismatches;
        int          strays;
        int          drops_seen;
        int          signals_seen;

        // works out the result of one item and advances the tracked state
        function t_key_result decode_keystroke(t_cmd cmd, logic [7:0] data, logic fg);
            t_key_result r;
            logic [7:0]  c;
            bit          want_push;
            int          nxt;
            int          level;
            r.char_out    = 8'h00;
            r.char_valid  = 1'b0;
            r.signal_code = SIG_NONE;
            r.pushed      = 1'b0;
            r.dropped     = 1'b0;
            c             = 8'h00;
            want_push     = 1'b0;
            case (cmd)
                CMD_SCAN: begin
                    if ((data & SC_RELEASE) != 8'h00) begin
                        // key release only matters for modifiers
                        if ((data & SC_CODE_MASK) == SC_LSHIFT ||
                            (data & SC_CODE_MASK) == SC_RSHIFT)
                            shift_on = 1'b0;
                        if ((data & SC_CODE_MASK) == SC_CTRL)
                            ctrl_on = 1'b0;
                    end else if (data == SC_LSHIFT || data == SC_RSHIFT) begin
                        shift_on = 1'b1;
                    end else if (data == SC_CTRL) begin
                        ctrl_on = 1'b1;
                    end else if (data == SC_CAPS) begin
                        caps_latched = !caps_latched;
                    end else begin
                        // table lookup, caps only without shift
                        if (data < MAP_LEN) begin
                            if (shift_on) begin
                                c = shift_keys[data[MAP_W-1:0]];
                            end else begin
                                c = plain_keys[data[MAP_W-1:0]];
                                if (caps_latched && c >= "a" && c <= "z")
                                    c = c - CASE_OFFSET;
                            end
                        end
                        if (ctrl_on && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
                            c = c & CTRL_MASK;
                        if (fg && c == CH_ETX)
                            r.signal_code = SIG_INT;
                        else if (fg && c == CH_SUB)
                            r.signal_code = SIG_STOP;
                        else if (c != 8'h00)
                            want_push = 1'b1;
                    end
                end
                CMD_INJECT: begin
                    c         = data;
                    want_push = (data != 8'h00);
                end
                CMD_POP: begin
                    if (rd_idx != wr_idx) begin
                        r.char_out   = char_ring[rd_idx];
                        r.char_valid = 1'b1;
                        rd_idx       = (rd_idx + 1) % FIFO_DEPTH;
                    end
                end
                default: begin
                end
            endcase
            // ring keeps one slot free
            if (want_push) begin
                nxt = (wr_idx + 1) % FIFO_DEPTH;
                if (nxt == rd_idx) begin
                    r.dropped = 1'b1;
                    drops_seen++;
                end else begin
                    char_ring[wr_idx] = c;
                    wr_idx            = nxt;
                    r.pushed          = 1'b1;
                end
            end
            if (r.signal_code != SIG_NONE)
                signals_seen++;
            level        = (wr_idx + FIFO_DEPTH - rd_idx) % FIFO_DEPTH;
            r.fifo_count = (level > 255) ? 8'd255 : level[7:0];
            return r;
        endfunction

        function void note_item(t_cmd cmd, logic [7:0] data, logic fg);
            expected_q.push_back(decode_keystroke(cmd, data, fg));
        endfunction

        function void check_result(t_key_result seen);
            t_key_result want;
            if (expected_q.size() == 0) begin
                strays++;
                if (mismatches + strays <= REPORT_MAX)
                    $display("unexpected result: char=%02h valid=%b sig=%0d count=%0d",
                             seen.char_out, seen.char_valid, seen.signal_code,
                             seen.fifo_count);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (seen !== want) begin
                mismatches++;
                if (mismatches + strays <= REPORT_MAX)
                    $display("result %0d mismatch: expected char=%02h valid=%b sig=%0d ",
                             checked, want.char_out, want.char_valid, want.signal_code,
                             "push=%b drop=%b count=%0d, ",
                             want.pushed, want.dropped, want.fifo_count,
                             "got char=%02h valid=%b sig=%0d ",
                             seen.char_out, seen.char_valid, seen.signal_code,
                             "push=%b drop=%b count=%0d",
                             seen.pushed, seen.dropped, seen.fifo_count);
            end
        endfunction

        function int faults();
            return mismatches + strays + expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   items_sent;
    bit   no_stall;

    key_decode_board tracker;

    ps2a_item_if   item_if ();
    ps2a_result_if result_if ();

    ps2_scancode_to_ascii_fifo dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        result_if.ready <= no_stall || ($urandom_range(0, 99) >= 25);
    end

    // check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            tracker.check_result('{result_if.char_out, result_if.char_valid,
                                   result_if.signal_code, result_if.pushed,
                                   result_if.dropped, result_if.fifo_count});
    end

    // drive one item, called at a falling edge, returns at a falling edge
    task automatic send_item(input t_cmd cmd, input logic [7:0] data, input logic fg);
        no_stall = (items_sent >= 1100 && items_sent < 1400);
        while (!no_stall && $urandom_range(0, 99) < 25) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid             <= 1'b1;
        item_if.cmd               <= cmd;
        item_if.data_byte         <= data;
        item_if.foreground_active <= fg;
        do
            @(posedge i_clk);
        while (!item_if.ready);
        tracker.note_item(cmd, data, fg);
        items_sent++;
        @(negedge i_clk);
    endtask

    // a burst of typing with modifiers around it
    task automatic type_phrase();
        bit         use_shift;
        bit         use_ctrl;
        logic [7:0] shift_code;
        logic [7:0] code;
        int         keys;
        use_shift  = ($urandom_range(0, 2) == 0);
        use_ctrl   = ($urandom_range(0, 4) == 0);
        shift_code = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
        keys       = $urandom_range(1, 6);
        if ($urandom_range(0, 7) == 0)
            send_item(CMD_SCAN, SC_CAPS, 1'($urandom_range(0, 1)));
        if (use_shift)
            send_item(CMD_SCAN, shift_code, 1'($urandom_range(0, 1)));
        if (use_ctrl)
            send_item(CMD_SCAN, SC_CTRL, 1'($urandom_range(0, 1)));
        repeat (keys) begin
            case ($urandom_range(0, 9))
                0: code = 8'($urandom_range(0, 255));
                1: code = $urandom_range(0, 1) ? KEY_C : KEY_Z;
                default: code = 8'($urandom_range(0, MAP_LEN - 1));
            endcase
            send_item(CMD_SCAN, code, 1'($urandom_range(0, 1)));
        end
        // a missed release leaves the modifier held into the next phrase
        if (use_ctrl && $urandom_range(0, 9) != 0)
            send_item(CMD_SCAN, SC_CTRL | SC_RELEASE, 1'($urandom_range(0, 1)));
        if (use_shift && $urandom_range(0, 9) != 0)
            send_item(CMD_SCAN, shift_code | SC_RELEASE, 1'($urandom_range(0, 1)));
    endtask

    // push well past full, then pop well past empty
    task automatic fill_then_drain();
        repeat (FIFO_DEPTH + 3)
            send_item(CMD_INJECT, 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        repeat (FIFO_DEPTH + 3)
            send_item(CMD_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        bit filled;
        tracker                   = new();
        filled                    = 1'b0;
        cycle_count               = 0;
        items_sent                = 0;
        no_stall                  = 1'b0;
        i_rst_n                   = 1'b0;
        item_if.valid             = 1'b0;
        item_if.cmd               = CMD_SCAN;
        item_if.data_byte         = 8'h00;
        item_if.foreground_active = 1'b0;
        result_if.ready           = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty pop, unused command, plain key, injected zero and high byte
        send_item(CMD_POP, 8'hFF, 1'b1);
        send_item(CMD_RSVD, 8'hFF, 1'b1);
        send_item(CMD_SCAN, KEY_A, 1'b0);
        send_item(CMD_INJECT, 8'h00, 1'b0);
        send_item(CMD_INJECT, 8'hFF, 1'b1);
        // unmapped codes and a stray release
        send_item(CMD_SCAN, 8'h00, 1'b1);
        send_item(CMD_SCAN, 8'h7F, 1'b0);
        send_item(CMD_SCAN, KEY_A | SC_RELEASE, 1'b0);
        // caps lock, then shift on top of it
        send_item(CMD_SCAN, SC_CAPS, 1'b0);
        send_item(CMD_SCAN, KEY_Q, 1'b0);
        send_item(CMD_SCAN, KEY_1, 1'b0);
        send_item(CMD_SCAN, SC_LSHIFT, 1'b0);
        send_item(CMD_SCAN, KEY_Q, 1'b0);
        send_item(CMD_SCAN, KEY_1, 1'b0);
        send_item(CMD_SCAN, SC_LSHIFT | SC_RELEASE, 1'b0);
        send_item(CMD_SCAN, SC_RSHIFT, 1'b0);
        send_item(CMD_SCAN, SC_RSHIFT | SC_RELEASE, 1'b0);
        send_item(CMD_SCAN, SC_CAPS, 1'b0);
        // ctrl: interrupt and stop with a foreground group, control codes otherwise
        send_item(CMD_SCAN, SC_CTRL, 1'b0);
        send_item(CMD_SCAN, KEY_C, 1'b1);
        send_item(CMD_SCAN, KEY_Z, 1'b1);
        send_item(CMD_SCAN, KEY_C, 1'b0);
        send_item(CMD_SCAN, KEY_A, 1'b1);
        send_item(CMD_SCAN, SC_CTRL | SC_RELEASE, 1'b0);
        send_item(CMD_POP, 8'h00, 1'b0);

        // random traffic, mostly typing
        while (items_sent < ITEM_GOAL) begin
            if (!filled && items_sent >= 700) begin
                fill_then_drain();
                filled = 1'b1;
            end
            case ($urandom_range(0, 9))
                5: repeat ($urandom_range(1, 4))
                    send_item(t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                6, 7, 9: repeat ($urandom_range(1, 8))
                    send_item(CMD_POP, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                8: repeat ($urandom_range(1, 8))
                    send_item(CMD_INJECT, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                default: type_phrase();
            endcase
        end
        item_if.valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (tracker.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d items, checked %0d results", items_sent, tracker.checked);
        $display("fifo overflows predicted: %0d, console signals predicted: %0d",
                 tracker.drops_seen, tracker.signals_seen);
        if (tracker.faults() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
